// ===== rtl/gem_pkg.sv =====
package gem_pkg;

   localparam int CHAN_BITS      = 8;
   localparam int PIXEL_BITS     = 3 * CHAN_BITS;
   localparam int KIND_BITS      = 2;
   localparam int WIDTH_BITS     = 11;
   localparam int ROW_BITS       = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int GRAD_BITS      = 11;
   localparam int SUM_BITS       = 22;
   localparam int ROOT_IN_BITS   = 16;
   localparam int TAP_COUNT      = 9;
   localparam int TAP_BITS       = 4;
   localparam int ROOT_STEPS     = 8;
   localparam int ROOT_SEL_BITS  = 3;
   localparam int WEIGHT_BITS    = 3;

   localparam logic ACT_PUSH  = 1'b0;
   localparam logic ACT_DRAIN = 1'b1;

   localparam logic [KIND_BITS-1:0] OP_ROBERTS = 2'd0;
   localparam logic [KIND_BITS-1:0] OP_PREWITT = 2'd1;
   localparam logic [KIND_BITS-1:0] OP_SOBEL   = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_OPERATOR = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEIGHT   = 2'd2;

   localparam logic [1:0] OFF_NEG  = 2'd0;
   localparam logic [1:0] OFF_ZERO = 2'd1;
   localparam logic [1:0] OFF_POS  = 2'd2;

   // tap t covers column offset t/3 - 1 and row offset t%3 - 1
   localparam logic [1:0] TAP_COL [TAP_COUNT] = '{
      OFF_NEG, OFF_NEG, OFF_NEG, OFF_ZERO, OFF_ZERO, OFF_ZERO, OFF_POS, OFF_POS, OFF_POS};
   localparam logic [1:0] TAP_ROW [TAP_COUNT] = '{
      OFF_NEG, OFF_ZERO, OFF_POS, OFF_NEG, OFF_ZERO, OFF_POS, OFF_NEG, OFF_ZERO, OFF_POS};

   // [kind][axis][tap]
   localparam logic signed [WEIGHT_BITS-1:0] WEIGHTS [3][2][TAP_COUNT] = '{
      '{ '{3'sd1, 3'sd0, 3'sd0, 3'sd0, -3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd0},
         '{3'sd0, 3'sd1, 3'sd0, -3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0} },
      '{ '{-3'sd1, 3'sd0, 3'sd1, -3'sd1, 3'sd0, 3'sd1, -3'sd1, 3'sd0, 3'sd1},
         '{-3'sd1, -3'sd1, -3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd1, 3'sd1, 3'sd1} },
      '{ '{-3'sd1, 3'sd0, 3'sd1, -3'sd2, 3'sd0, 3'sd2, -3'sd1, 3'sd0, 3'sd1},
         '{-3'sd1, -3'sd2, -3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd1, 3'sd2, 3'sd1} }
   };

   typedef struct packed {
      logic                     clear;
      logic                     accum;
      logic                     square;
      logic                     root_step;
      logic [TAP_BITS-1:0]      tap;
      logic [KIND_BITS-1:0]     kind;
      logic [ROOT_SEL_BITS-1:0] bit_sel;
   } lane_ctl_type;

endpackage

// ===== rtl/gem_ram.sv =====
module gem_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gem_lane.sv =====
module gem_lane (
   input  logic                                 clock,
   input  gem_pkg::lane_ctl_type                ctl,
   input  logic [gem_pkg::CHAN_BITS-1:0]        pix,
   output logic [gem_pkg::CHAN_BITS-1:0]        mag
);

   logic signed [gem_pkg::GRAD_BITS-1:0]   gx_ff, gx_in, gy_ff, gy_in;
   logic signed [gem_pkg::GRAD_BITS-1:0]   pix_s, wx_s, wy_s;
   logic signed [gem_pkg::SUM_BITS-1:0]    gx2, gy2, sum;
   logic [gem_pkg::ROOT_IN_BITS-1:0]       sq_ff, sq_in, trial_sq;
   logic                                   sat_ff, sat_in;
   logic [gem_pkg::CHAN_BITS-1:0]          root_ff, root_in, trial;

   always_comb begin
      pix_s    = gem_pkg::GRAD_BITS'($signed({1'b0, pix}));
      wx_s     = gem_pkg::GRAD_BITS'(gem_pkg::WEIGHTS[ctl.kind][0][ctl.tap]);
      wy_s     = gem_pkg::GRAD_BITS'(gem_pkg::WEIGHTS[ctl.kind][1][ctl.tap]);
      gx2      = gem_pkg::SUM_BITS'(gx_ff) * gem_pkg::SUM_BITS'(gx_ff);
      gy2      = gem_pkg::SUM_BITS'(gy_ff) * gem_pkg::SUM_BITS'(gy_ff);
      sum      = gx2 + gy2;
      trial    = root_ff | (gem_pkg::CHAN_BITS'(1) << ctl.bit_sel);
      trial_sq = gem_pkg::ROOT_IN_BITS'(trial) * gem_pkg::ROOT_IN_BITS'(trial);
      gx_in    = gx_ff;
      gy_in    = gy_ff;
      sq_in    = sq_ff;
      sat_in   = sat_ff;
      root_in  = root_ff;
      if (ctl.clear) begin
         gx_in = '0;
         gy_in = '0;
      end else if (ctl.accum) begin
         gx_in = gx_ff + wx_s * pix_s;
         gy_in = gy_ff + wy_s * pix_s;
      end
      if (ctl.square) begin
         sq_in   = sum[gem_pkg::ROOT_IN_BITS-1:0];
         sat_in  = |sum[gem_pkg::SUM_BITS-1:gem_pkg::ROOT_IN_BITS];
         root_in = '0;
      end else if (ctl.root_step) begin
         if (trial_sq <= sq_ff) begin
            root_in = trial;
         end
      end
   end

   always_ff @(posedge clock) begin
      gx_ff   <= gx_in;
      gy_ff   <= gy_in;
      sq_ff   <= sq_in;
      sat_ff  <= sat_in;
      root_ff <= root_in;
   end

   assign mag = sat_ff ? '1 : root_ff;

endmodule

// ===== rtl/gradient_edge_magnitude_rgb_core.sv =====
// Gradient magnitude per color channel (Roberts, Prewitt or Sobel) on a raster RGB
// request stream, edge pixels replicated. The result for pixel p leaves with the push of
// pixel p+W+1; after a frame, drain requests flush the rest one by one. A request that
// yields a result holds off the next request until its result is in the output
// register: it is accepted, the nine window reads go through the single read port of the
// four-row line store, the squares are formed, the bit-serial square root runs and the
// result moves into the output register, later while an earlier result is still
// stalled there. The three channels run in parallel lanes. The line store needs no
// clearing pass after reset. Any register write abandons the frame in progress.
module gradient_edge_magnitude_rgb_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [gem_pkg::CHAN_BITS-1:0]       req_red_in,
   input  logic [gem_pkg::CHAN_BITS-1:0]       req_green_in,
   input  logic [gem_pkg::CHAN_BITS-1:0]       req_blue_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [gem_pkg::CHAN_BITS-1:0]       rsp_red_mag,
   output logic [gem_pkg::CHAN_BITS-1:0]       rsp_green_mag,
   output logic [gem_pkg::CHAN_BITS-1:0]       rsp_blue_mag,
   output logic                                rsp_last_of_frame,
   input  logic                                csr_we,
   input  logic [gem_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [gem_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int CW      = $clog2(MAX_WIDTH);
   localparam int WW      = $clog2(MAX_WIDTH + 1);
   localparam int PW      = $clog2(MAX_WIDTH + 2);
   localparam int DEPTH   = 4 * MAX_WIDTH;
   localparam int AW      = $clog2(DEPTH);
   localparam int RESET_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
   localparam int RB      = gem_pkg::ROW_BITS;
   localparam int CB      = gem_pkg::CHAN_BITS;

   typedef enum logic [2:0] {ST_IDLE, ST_TAPS, ST_SQUARE, ST_ROOT, ST_HOLD} state_type;

   state_type                        state_ff, state_in;
   logic [gem_pkg::TAP_BITS-1:0]     cnt_ff, cnt_in;
   logic [gem_pkg::KIND_BITS-1:0]    kind_ff, kind_in;
   logic [WW-1:0]                    width_ff, width_in;
   logic [RB-1:0]                    height_ff, height_in;
   logic [CW-1:0]                    col_ff, col_in, ex_ff, ex_in, cur_x_ff, cur_x_in;
   logic [RB-1:0]                    row_ff, row_in, ey_ff, ey_in, cur_y_ff, cur_y_in;
   logic [PW-1:0]                    pend_ff, pend_in, pend_base;
   logic                             cur_last_ff, cur_last_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [CB-1:0]                    red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic                             last_ff, last_in;

   logic                             accept, done, is_push, emit;
   logic [CW-1:0]                    ex_base, tx;
   logic [RB-1:0]                    ey_base, ty;
   logic [gem_pkg::WIDTH_BITS-1:0]   fw;
   logic [gem_pkg::TAP_BITS-1:0]     rd_tap;
   logic                             wr_en, rd_en;
   logic [AW-1:0]                    wr_addr, rd_addr;
   logic [gem_pkg::PIXEL_BITS-1:0]   rd_data;
   gem_pkg::lane_ctl_type            lane_ctl;
   logic [CB-1:0]                    red_mag, green_mag, blue_mag;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_push   = (req_action == gem_pkg::ACT_PUSH);
   assign done      = (col_ff == '0) && (row_ff == '0) && (pend_ff != '0);
   assign pend_base = (is_push && done) ? '0 : pend_ff;
   assign ex_base   = (is_push && done) ? '0 : ex_ff;
   assign ey_base   = (is_push && done) ? '0 : ey_ff;
   assign emit      = accept && (is_push ? (pend_base > PW'(width_ff)) : done);
   assign fw        = csr_wdata[gem_pkg::WIDTH_BITS-1:0];

   assign wr_en   = accept && is_push;
   assign wr_addr = AW'(row_ff[1:0]) * AW'(MAX_WIDTH) + AW'(col_ff);
   assign rd_tap  = (cnt_ff < gem_pkg::TAP_BITS'(gem_pkg::TAP_COUNT)) ? cnt_ff : '0;
   assign rd_en   = (state_ff == ST_TAPS) && (cnt_ff < gem_pkg::TAP_BITS'(gem_pkg::TAP_COUNT));
   assign rd_addr = AW'(ty[1:0]) * AW'(MAX_WIDTH) + AW'(tx);

   always_comb begin
      case (gem_pkg::TAP_COL[rd_tap])
         gem_pkg::OFF_NEG: tx = (cur_x_ff == '0) ? cur_x_ff : cur_x_ff - 1'b1;
         gem_pkg::OFF_POS: tx = (WW'(cur_x_ff) == width_ff - 1'b1) ? cur_x_ff : cur_x_ff + 1'b1;
         default:          tx = cur_x_ff;
      endcase
      case (gem_pkg::TAP_ROW[rd_tap])
         gem_pkg::OFF_NEG: ty = (cur_y_ff == '0) ? cur_y_ff : cur_y_ff - 1'b1;
         gem_pkg::OFF_POS: ty = (cur_y_ff == height_ff - 1'b1) ? cur_y_ff : cur_y_ff + 1'b1;
         default:          ty = cur_y_ff;
      endcase
   end

   always_comb begin
      lane_ctl           = '0;
      lane_ctl.kind      = kind_ff;
      lane_ctl.clear     = (state_ff == ST_TAPS) && (cnt_ff == '0);
      lane_ctl.accum     = (state_ff == ST_TAPS) && (cnt_ff != '0);
      lane_ctl.tap       = (cnt_ff != '0) ? cnt_ff - 1'b1 : '0;
      lane_ctl.square    = (state_ff == ST_SQUARE);
      lane_ctl.root_step = (state_ff == ST_ROOT);
      lane_ctl.bit_sel   = gem_pkg::ROOT_SEL_BITS'(gem_pkg::ROOT_STEPS - 1)
                           - cnt_ff[gem_pkg::ROOT_SEL_BITS-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      kind_in      = kind_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pend_in      = pend_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cur_last_in  = cur_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      last_in      = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_push) begin
                  if (WW'(col_ff) == width_ff - 1'b1) begin
                     col_in = '0;
                     row_in = (row_ff == height_ff - 1'b1) ? '0 : row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
                  pend_in = emit ? pend_base : pend_base + 1'b1;
               end else if (emit) begin
                  pend_in = pend_ff - 1'b1;
               end
               ex_in = ex_base;
               ey_in = ey_base;
               if (emit) begin
                  cur_x_in    = ex_base;
                  cur_y_in    = ey_base;
                  cur_last_in = (WW'(ex_base) == width_ff - 1'b1)
                                && (ey_base == height_ff - 1'b1);
                  if (WW'(ex_base) == width_ff - 1'b1) begin
                     ex_in = '0;
                     ey_in = (ey_base == height_ff - 1'b1) ? '0 : ey_base + 1'b1;
                  end else begin
                     ex_in = ex_base + 1'b1;
                  end
                  cnt_in   = '0;
                  state_in = ST_TAPS;
               end
            end
         end
         ST_TAPS: begin
            if (cnt_ff == gem_pkg::TAP_BITS'(gem_pkg::TAP_COUNT)) begin
               state_in = ST_SQUARE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SQUARE: begin
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (cnt_ff == gem_pkg::TAP_BITS'(gem_pkg::ROOT_STEPS - 1)) begin
               state_in = ST_HOLD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               red_in       = red_mag;
               green_in     = green_mag;
               blue_in      = blue_mag;
               last_in      = cur_last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            gem_pkg::CSR_OPERATOR: begin
               kind_in = (csr_wdata[gem_pkg::KIND_BITS-1:0] > gem_pkg::OP_SOBEL)
                         ? gem_pkg::OP_SOBEL : csr_wdata[gem_pkg::KIND_BITS-1:0];
            end
            gem_pkg::CSR_WIDTH: begin
               if (fw == '0) begin
                  width_in = WW'(1);
               end else if (32'(fw) > MAX_WIDTH) begin
                  width_in = WW'(MAX_WIDTH);
               end else begin
                  width_in = WW'(fw);
               end
            end
            gem_pkg::CSR_HEIGHT: begin
               height_in = (csr_wdata == '0) ? RB'(1) : csr_wdata;
            end
            default: begin
            end
         endcase
         if (csr_index == gem_pkg::CSR_OPERATOR || csr_index == gem_pkg::CSR_WIDTH
             || csr_index == gem_pkg::CSR_HEIGHT) begin
            col_in  = '0;
            row_in  = '0;
            pend_in = '0;
            ex_in   = '0;
            ey_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         kind_ff      <= gem_pkg::OP_SOBEL;
         width_ff     <= WW'(RESET_W);
         height_ff    <= RB'(480);
         col_ff       <= '0;
         row_ff       <= '0;
         pend_ff      <= '0;
         ex_ff        <= '0;
         ey_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         kind_ff      <= kind_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pend_ff      <= pend_in;
         ex_ff        <= ex_in;
         ey_ff        <= ey_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      cur_last_ff <= cur_last_in;
      red_ff      <= red_in;
      green_ff    <= green_in;
      blue_ff     <= blue_in;
      last_ff     <= last_in;
   end

   gem_ram #(
      .WIDTH (gem_pkg::PIXEL_BITS),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_red_in, req_green_in, req_blue_in}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gem_lane u_lane_red (
      .clock (clock),
      .ctl   (lane_ctl),
      .pix   (rd_data[3*CB-1:2*CB]),
      .mag   (red_mag)
   );

   gem_lane u_lane_green (
      .clock (clock),
      .ctl   (lane_ctl),
      .pix   (rd_data[2*CB-1:CB]),
      .mag   (green_mag)
   );

   gem_lane u_lane_blue (
      .clock (clock),
      .ctl   (lane_ctl),
      .pix   (rd_data[CB-1:0]),
      .mag   (blue_mag)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_red_mag       = red_ff;
   assign rsp_green_mag     = green_ff;
   assign rsp_blue_mag      = blue_ff;
   assign rsp_last_of_frame = last_ff;

endmodule

// ===== rtl/gem_checker.sv =====
module gem_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [gem_pkg::CHAN_BITS-1:0] rsp_red_mag,
   input logic [gem_pkg::CHAN_BITS-1:0] rsp_green_mag,
   input logic [gem_pkg::CHAN_BITS-1:0] rsp_blue_mag,
   input logic                          rsp_last_of_frame
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_red_mag) && $stable(rsp_green_mag)
                                 && $stable(rsp_blue_mag) && $stable(rsp_last_of_frame))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   a_rise_after_work: assert property (@(posedge clock)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without computation");

endmodule

bind gradient_edge_magnitude_rgb_core gem_checker u_gem_checker (.*);

// ===== sim/gradient_edge_magnitude_rgb_core_tb.sv =====
module gradient_edge_magnitude_rgb_core_tb;

   localparam int MAXW       = 1024;
   localparam int IDLE_LIMIT = 5000;
   localparam int SETTLE     = 30;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } magnitude_type;

   class magnitude_scoreboard;
      logic [gem_pkg::PIXEL_BITS-1:0] rows [4*MAXW];
      int unsigned kind, fwidth, fheight, col, row, owed;
      magnitude_type owed_q [$];
      int          fails;

      function new();
         foreach (rows[i]) rows[i] = '0;
         kind = gem_pkg::OP_SOBEL; fwidth = 640; fheight = 480;
         col = 0; row = 0; owed = 0; fails = 0;
      endfunction

      function int unsigned cur_width();
         if (fwidth == 0) return 1;
         if (fwidth > MAXW) return MAXW;
         return fwidth;
      endfunction

      function int unsigned cur_height();
         return (fheight == 0) ? 1 : fheight;
      endfunction

      function logic [7:0] clamped_root(int unsigned s);
         int unsigned r, t;
         r = 0;
         if (s >= 65536) return 8'd255;
         for (int b = 7; b >= 0; b--) begin
            t = r | (1 << b);
            if (t * t <= s) r = t;
         end
         return r[7:0];
      endfunction

      function void queue_magnitude(int unsigned e, int unsigned w, int unsigned h);
         int x, y, cx, cy, k, wx, wy, v;
         int gx [3];
         int gy [3];
         logic [gem_pkg::PIXEL_BITS-1:0] px;
         logic [7:0] m [3];
         magnitude_type res;
         x = e % w;
         y = e / w;
         k = (kind > gem_pkg::OP_SOBEL) ? gem_pkg::OP_SOBEL : kind;
         for (int c = 0; c < 3; c++) begin
            gx[c] = 0;
            gy[c] = 0;
         end
         for (int kx = 0; kx < 3; kx++) begin
            for (int ky = 0; ky < 3; ky++) begin
               cx = x + kx - 1;
               cy = y + ky - 1;
               if (cx < 0) cx = 0;
               if (cx > int'(w) - 1) cx = w - 1;
               if (cy < 0) cy = 0;
               if (cy > int'(h) - 1) cy = h - 1;
               px = rows[((cy & 3) * MAXW + cx) % (4 * MAXW)];
               wx = gem_pkg::WEIGHTS[k][0][kx*3+ky];
               wy = gem_pkg::WEIGHTS[k][1][kx*3+ky];
               for (int c = 0; c < 3; c++) begin
                  v = px[16-8*c +: 8];
                  gx[c] += wx * v;
                  gy[c] += wy * v;
               end
            end
         end
         for (int c = 0; c < 3; c++) m[c] = clamped_root(gx[c]*gx[c] + gy[c]*gy[c]);
         res.red = m[0];
         res.green = m[1];
         res.blue = m[2];
         res.last = (e == w * h - 1);
         owed_q.push_back(res);
      endfunction

      function void write_reg(logic [gem_pkg::CSR_INDEX_BITS-1:0] idx,
                              logic [gem_pkg::CSR_DATA_BITS-1:0] val);
         case (idx)
            gem_pkg::CSR_OPERATOR: kind = val[gem_pkg::KIND_BITS-1:0];
            gem_pkg::CSR_WIDTH:    fwidth = val[gem_pkg::WIDTH_BITS-1:0];
            gem_pkg::CSR_HEIGHT:   fheight = val[gem_pkg::ROW_BITS-1:0];
            default: return;
         endcase
         col = 0; row = 0; owed = 0;
      endfunction

      function void note_request(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
         int unsigned w, h, n, pushed;
         bit done;
         w = cur_width();
         h = cur_height();
         n = w * h;
         done = (col == 0) && (row == 0) && (owed > 0);
         if (act == gem_pkg::ACT_DRAIN) begin
            if (!done) return;
            queue_magnitude(n - owed, w, h);
            owed--;
            return;
         end
         if (done) owed = 0;
         if (col >= w || row >= h) begin
            col = 0; row = 0; owed = 0;
         end
         rows[((row & 3) * MAXW + col) % (4 * MAXW)] = {r, g, b};
         pushed = row * w + col + 1;
         col++;
         if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
         end
         owed++;
         if (owed > w + 1) begin
            queue_magnitude(pushed - owed, w, h);
            owed--;
         end
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         fails++;
      endtask

      task check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
         magnitude_type e;
         if (owed_q.size() == 0) begin
            report($sformatf("unexpected result %0d %0d %0d last %0d", r, g, b, last));
            return;
         end
         e = owed_q.pop_front();
         if (r !== e.red) report($sformatf("red %0d, want %0d", r, e.red));
         if (g !== e.green) report($sformatf("green %0d, want %0d", g, e.green));
         if (b !== e.blue) report($sformatf("blue %0d, want %0d", b, e.blue));
         if (last !== e.last) report($sformatf("last_of_frame %0d, want %0d", last, e.last));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_action = gem_pkg::ACT_PUSH;
   logic [7:0] req_red_in = 0, req_green_in = 0, req_blue_in = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [7:0] rsp_red_mag, rsp_green_mag, rsp_blue_mag;
   logic rsp_last_of_frame;
   logic csr_we = 0;
   logic [gem_pkg::CSR_INDEX_BITS-1:0] csr_index = gem_pkg::CSR_OPERATOR;
   logic [gem_pkg::CSR_DATA_BITS-1:0] csr_wdata = 0;

   magnitude_scoreboard sb = new();
   int burst_left = 0;
   int random_items = 0;
   int idle_cycles = 0;
   bit hold_req = 0;

   always #5 clock = ~clock;

   gradient_edge_magnitude_rgb_core DUT (.*);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_red_mag, rsp_green_mag, rsp_blue_mag, rsp_last_of_frame);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("gradient_edge_magnitude_rgb_core verification failed");
         $finish;
      end
   end

   initial begin
      int mode, len;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_stall = 1;
            repeat (400) @(negedge clock);
            hold_req = 0;
         end
         mode = $urandom_range(0, 3);
         len = $urandom_range(5, 60);
         for (int i = 0; i < len && !hold_req; i++) begin
            case (mode)
               0: rsp_stall = 0;
               1: rsp_stall = ($urandom_range(0, 2) == 0);
               2: rsp_stall = (i % 4 == 3);
               default: rsp_stall = ($urandom_range(0, 1) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   task send_request(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end
      req_action = act;
      req_red_in = r;
      req_green_in = g;
      req_blue_in = b;
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      sb.note_request(act, r, g, b);
      burst_left--;
      @(negedge clock);
      req_valid = 0;
   endtask

   task wait_drained();
      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   task write_reg(logic [gem_pkg::CSR_INDEX_BITS-1:0] idx,
                  logic [gem_pkg::CSR_DATA_BITS-1:0] val);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_we = 0;
   endtask

   task set_geometry(int k, int w, int h);
      wait_drained();
      write_reg(gem_pkg::CSR_OPERATOR, gem_pkg::CSR_DATA_BITS'(k)
                | gem_pkg::CSR_DATA_BITS'($urandom & 32'hFFFC));
      write_reg(gem_pkg::CSR_WIDTH, gem_pkg::CSR_DATA_BITS'(w)
                | gem_pkg::CSR_DATA_BITS'($urandom & 32'hF800));
      write_reg(gem_pkg::CSR_HEIGHT, gem_pkg::CSR_DATA_BITS'(h));
   endtask

   function logic [7:0] pick_chan(int style);
      case (style)
         0: return 8'($urandom);
         1: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         default: return 8'($urandom_range(0, 7));
      endcase
   endfunction

   task send_frame(int pushes, int drains, int noise, bit counted);
      int style;
      style = $urandom_range(0, 2);
      for (int i = 0; i < pushes; i++) begin
         if ($urandom_range(0, 99) < noise) begin
            send_request(gem_pkg::ACT_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
            if (counted) random_items++;
         end
         send_request(gem_pkg::ACT_PUSH, pick_chan(style), pick_chan(style), pick_chan(style));
         if (counted) random_items++;
      end
      for (int i = 0; i < drains; i++) begin
         send_request(gem_pkg::ACT_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
         if (counted) random_items++;
      end
   endtask

   initial begin
      int k, w, h, ew, eh;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // extreme pixels with every operator, then edge-case operator and geometry values
      for (int op = gem_pkg::OP_ROBERTS; op <= gem_pkg::OP_SOBEL; op++) begin
         set_geometry(op, 2, 2);
         for (int i = 0; i < 4; i++)
            send_request(gem_pkg::ACT_PUSH, (i % 2) ? 8'hFF : 8'h00,
                         (i < 2) ? 8'hFF : 8'h00, 8'hFF);
         send_frame(0, 4, 0, 0);
      end
      set_geometry(3, 0, 0);
      send_frame(0, 1, 0, 0);
      send_frame(1, 2, 0, 0);
      set_geometry(gem_pkg::OP_SOBEL, 3, 3);
      send_frame(9, 2, 0, 0);
      send_frame(3, 0, 0, 0);
      set_geometry(gem_pkg::OP_PREWITT, 2047, 1);
      send_frame(16, 2, 0, 0);
      set_geometry(gem_pkg::OP_ROBERTS, 2, 65535);
      send_frame(10, 1, 0, 0);

      // fill the block while the receiver holds off
      set_geometry(gem_pkg::OP_SOBEL, 4, 6);
      hold_req = 1;
      send_frame(24, 5, 0, 0);

      while (random_items < 1050) begin
         k = $urandom_range(0, 3);
         w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
         h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
         set_geometry(k, w, h);
         ew = (w == 0) ? 1 : w;
         eh = (h == 0) ? 1 : h;
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 9) == 0) wait_drained();
            if ($urandom_range(0, 5) == 0)
               send_frame($urandom_range(1, ew * eh), $urandom_range(0, ew + 2), 10, 1);
            else
               send_frame(ew * eh, ew + 1 + $urandom_range(0, 2), 3, 1);
         end
      end

      wait_drained();
      if (sb.owed_q.size() != 0) sb.report("results still owed at end of run");
      if (sb.fails == 0)
         $display("gradient_edge_magnitude_rgb_core verification clean");
      else
         $display("gradient_edge_magnitude_rgb_core verification failed");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/gem_pkg.sv
rtl/gem_ram.sv
rtl/gem_lane.sv
rtl/gradient_edge_magnitude_rgb_core.sv
rtl/gem_checker.sv
sim/gradient_edge_magnitude_rgb_core_tb.sv
